// File: hw/rtl/tte_pkg.sv
package tte_pkg;

    // Ring of tap timestamps.
    localparam int TAP_SLOTS  = 8;
    localparam int SLOT_W     = (TAP_SLOTS > 1) ? $clog2(TAP_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TAP_SLOTS + 1);

    // Field widths.
    localparam int TIME_W     = 32;
    localparam int GAP_W      = 16;
    localparam int WIN_W      = 4;
    localparam int BPM_W      = 14;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // 60000 ms per minute times 16 for the Q10.4 result.
    localparam int BPM_SCALE  = 960000;
    localparam int NUM_W      = $clog2(BPM_SCALE * (TAP_SLOTS - 1) + 1);
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    localparam logic [GAP_W-1:0] RESET_GAP_DEFAULT = GAP_W'(2000);
    localparam logic [WIN_W-1:0] SAMPLES_DEFAULT   = WIN_W'(4);
    localparam logic [BPM_W-1:0] MIN_BPM_DEFAULT   = BPM_W'(640);
    localparam logic [BPM_W-1:0] MAX_BPM_DEFAULT   = BPM_W'(3840);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_GAP = 2'd0,
        CFG_SAMPLES   = 2'd1,
        CFG_MIN_BPM   = 2'd2,
        CFG_MAX_BPM   = 2'd3
    } tte_cfg_idx_t;

    typedef struct packed {
        logic [GAP_W-1:0] reset_gap_ms;
        logic [WIN_W-1:0] samples_in_use;
        logic [BPM_W-1:0] min_bpm_q4;
        logic [BPM_W-1:0] max_bpm_q4;
    } tte_cfg_t;

    // One division job handed from the tap tracker to the divider.
    typedef struct packed {
        logic              ok;        // at least two taps in the window
        logic [SLOT_W-1:0] span;      // taps in the window minus one
        logic [TIME_W-1:0] interval;  // newest minus oldest timestamp
    } tte_job_t;

    typedef struct packed {
        logic     avail;
        tte_job_t job;
    } tte_q_head_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_PUSH
    } tte_front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } tte_back_state_t;

endpackage

// File: hw/rtl/tte_front.sv
module tte_front
    import tte_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  tte_cfg_t          cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [TIME_W-1:0] s_tap_time_ms,
    input  logic              q_full,
    output logic              q_push,
    output tte_job_t          q_job
);

    tte_front_state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [SLOT_W-1:0] newest_reg;
    logic [SLOT_W-1:0] oldest_reg;
    logic [SLOT_W-1:0] span_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] old_time_reg;
    logic [TIME_W-1:0] tap_mem [TAP_SLOTS];

    logic              accept;
    logic [CNT_W-1:0]  limit;
    logic [TIME_W-1:0] gap;
    logic              restart;
    logic [CNT_W-1:0]  base;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  count_next;
    logic [SLOT_W-1:0] newest_next;
    logic [SLOT_W-1:0] span_next;
    logic [SLOT_W:0]   wrap_sum;
    logic [SLOT_W-1:0] oldest_next;

    assign accept = s_valid && s_ready;

    // Window size, forced into one to TAP_SLOTS.
    always_comb begin
        if (cfg.samples_in_use == '0) begin
            limit = CNT_W'(1);
        end else if (int'(cfg.samples_in_use) > TAP_SLOTS) begin
            limit = CNT_W'(TAP_SLOTS);
        end else begin
            limit = CNT_W'(cfg.samples_in_use);
        end
    end

    always_comb begin
        gap     = s_tap_time_ms - last_time_reg;
        restart = (count_reg == '0) || (gap > TIME_W'(cfg.reset_gap_ms));
        base    = restart ? '0 : count_reg;

        if (restart) begin
            newest_next = '0;
        end else if (newest_reg == SLOT_W'(TAP_SLOTS - 1)) begin
            newest_next = '0;
        end else begin
            newest_next = newest_reg + 1'b1;
        end

        cnt_inc    = (int'(base) < TAP_SLOTS) ? base + 1'b1 : base;
        count_next = (cnt_inc > limit) ? limit : cnt_inc;
        span_next  = SLOT_W'(count_next - 1'b1);

        wrap_sum = {1'b0, newest_next} + (SLOT_W+1)'(TAP_SLOTS) - {1'b0, span_next};
        if (newest_next >= span_next) begin
            oldest_next = newest_next - span_next;
        end else begin
            oldest_next = wrap_sum[SLOT_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_READ;
                end
            end
            F_READ: begin
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready = 1'b0;
        q_push  = 1'b0;
        case (state_reg)
            F_IDLE:  s_ready = 1'b1;
            F_READ:  s_ready = 1'b0;
            F_PUSH:  q_push  = !q_full;
            default: s_ready = 1'b0;
        endcase
    end

    assign q_job.ok       = (count_reg >= CNT_W'(2));
    assign q_job.span     = span_reg;
    assign q_job.interval = last_time_reg - old_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            count_reg  <= '0;
            newest_reg <= '0;
            oldest_reg <= '0;
            span_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                count_reg  <= count_next;
                newest_reg <= newest_next;
                oldest_reg <= oldest_next;
                span_reg   <= span_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_time_reg <= s_tap_time_ms;
        end
    end

    // Timestamp ring: written on a transfer, oldest entry read in the F_READ state that follows.
    always_ff @(posedge aclk) begin
        if (accept) begin
            tap_mem[newest_next] <= s_tap_time_ms;
        end
        if (state_reg == F_READ) begin
            old_time_reg <= tap_mem[oldest_reg];
        end
    end

endmodule

// File: hw/rtl/tte_queue.sv
module tte_queue
    import tte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  tte_job_t    push_job,
    output logic        full,
    input  logic        pop,
    output tte_q_head_t head
);

    tte_job_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign full       = (fill_reg == 2'd2);
    assign head.avail = (fill_reg != 2'd0);
    assign head.job   = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && head.avail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/tte_back.sv
module tte_back
    import tte_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  tte_cfg_t         cfg,
    input  tte_q_head_t      head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_bpm_valid,
    output logic [BPM_W-1:0] m_bpm_q4
);

    tte_back_state_t state_reg, state_next;

    logic                 ok_reg;
    logic [TIME_W-1:0]    divisor_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 m_valid_reg;
    logic                 m_ok_reg;
    logic [BPM_W-1:0]     m_bpm_reg;

    logic                 load;
    logic                 step;
    logic                 finish;
    logic                 slot_free;
    logic                 skip_div;
    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      trial_diff;
    logic                 qbit;
    logic [NUM_W-1:0]     lo_clamped;
    logic [NUM_W-1:0]     bpm_full;
    logic [BPM_W-1:0]     bpm_result;

    assign slot_free = !m_valid_reg || m_ready;
    assign skip_div  = !head.job.ok || (head.job.interval == '0);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (head.avail) begin
                    state_next = skip_div ? B_DONE : B_DIV;
                end
            end
            B_DIV: begin
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    state_next = B_DONE;
                end
            end
            B_DONE: begin
                if (slot_free) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        load   = 1'b0;
        step   = 1'b0;
        finish = 1'b0;
        case (state_reg)
            B_IDLE:  load   = head.avail;
            B_DIV:   step   = 1'b1;
            B_DONE:  finish = slot_free;
            default: load   = 1'b0;
        endcase
    end

    assign q_pop = load;

    // One restoring step: bring down the next numerator bit.
    always_comb begin
        trial      = {rem_reg, num_reg[NUM_W-1]};
        trial_diff = trial - {1'b0, divisor_reg};
        qbit       = (trial >= {1'b0, divisor_reg});
    end

    // Clamp below first, then above, so crossed limits give the upper one.
    always_comb begin
        lo_clamped = (quo_reg < NUM_W'(cfg.min_bpm_q4)) ? NUM_W'(cfg.min_bpm_q4) : quo_reg;
        bpm_full   = (lo_clamped > NUM_W'(cfg.max_bpm_q4)) ?
                     NUM_W'(cfg.max_bpm_q4) : lo_clamped;
        if (!ok_reg) begin
            bpm_result = '0;
        end else if (divisor_reg == '0) begin
            bpm_result = cfg.max_bpm_q4;
        end else begin
            bpm_result = bpm_full[BPM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ok_reg      <= head.job.ok;
            divisor_reg <= head.job.interval;
            rem_reg     <= '0;
            quo_reg     <= '0;
            num_reg     <= NUM_W'(BPM_SCALE * int'(head.job.span));
            cnt_reg     <= DIV_CNT_W'(NUM_W);
        end else if (step) begin
            rem_reg <= qbit ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], qbit};
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (finish) begin
            m_ok_reg  <= ok_reg;
            m_bpm_reg <= bpm_result;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bpm_valid = m_ok_reg;
    assign m_bpm_q4    = m_bpm_reg;

endmodule

// File: hw/rtl/tap_tempo_estimator_top.sv
// Channel   Ports                                   Direction  Transfer when
// tap       s_valid s_ready s_tap_time_ms           in         s_valid && s_ready
// tempo     m_valid m_ready m_bpm_valid m_bpm_q4    out        m_valid && m_ready
// config    cfg_wr_en cfg_index cfg_wr_data         in         cfg_wr_en
//
// In the tap tracker a tap goes through the transfer, the ring read and the hand-off.
// The bit-serial divider then works on one job at a time and takes the next one only
// after its result has been placed in the output register.
// Reset is synchronous and active low; it empties the tap window, the job queue and the
// output register and restores the register defaults.
// A stalled result stops the divider after one more job; taps go on until the queue fills.
module tap_tempo_estimator_top
    import tte_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TIME_W-1:0]     s_tap_time_ms,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_bpm_valid,
    output logic [BPM_W-1:0]      m_bpm_q4,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    // Configuration registers. Each write takes the low bits of the data
    // word that the register is wide.
    tte_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_gap_ms   <= RESET_GAP_DEFAULT;
            cfg_reg.samples_in_use <= SAMPLES_DEFAULT;
            cfg_reg.min_bpm_q4     <= MIN_BPM_DEFAULT;
            cfg_reg.max_bpm_q4     <= MAX_BPM_DEFAULT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RESET_GAP: cfg_reg.reset_gap_ms   <= cfg_wr_data[GAP_W-1:0];
                CFG_SAMPLES:   cfg_reg.samples_in_use <= cfg_wr_data[WIN_W-1:0];
                CFG_MIN_BPM:   cfg_reg.min_bpm_q4     <= cfg_wr_data[BPM_W-1:0];
                CFG_MAX_BPM:   cfg_reg.max_bpm_q4     <= cfg_wr_data[BPM_W-1:0];
                default:       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // The tap tracker keeps the timestamp ring, decides on a restart after a
    // long gap, trims the window and produces the interval to divide by.
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    tte_job_t    q_job;
    tte_q_head_t q_head;

    tte_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_tap_time_ms (s_tap_time_ms),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_job)
    );

    // Short job queue, so that the tracker can take the next tap while the
    // divider is busy or the result is stalled.
    tte_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    // The divider forms 960000 * (taps - 1) / interval one quotient bit per cycle, clamps it
    // and registers it; under two taps give zero, a zero interval the upper limit.
    tte_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .head        (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bpm_valid (m_bpm_valid),
        .m_bpm_q4    (m_bpm_q4)
    );

endmodule

// File: hw/rtl/tte_checker.sv
module tte_checker
    import tte_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_bpm_valid,
    input logic [BPM_W-1:0] m_bpm_q4
);

    // A waiting result is held until its transfer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bpm_valid) && $stable(m_bpm_q4))
        else $error("result changed or dropped while stalled");

    // A result without two taps carries a zero tempo.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_bpm_valid |-> m_bpm_q4 == '0)
        else $error("tempo not zero on a result that is not valid");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // The tap tracker works on one tap at a time and needs the ring read
    // before the next tap.
    a_tap_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("tap taken before the previous one was handed on");

    // No result can appear before a tap has passed the tap tracker and the queue;
    // right after reset no tap has been taken, so the output stays quiet.
    a_no_early_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid ##1 !m_valid ##1 !m_valid)
        else $error("result appeared before any tap could reach it");

endmodule

bind tap_tempo_estimator_top tte_checker u_tte_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_bpm_valid (m_bpm_valid),
    .m_bpm_q4    (m_bpm_q4)
);
